/* rtl/core/ddi_pkg.sv */
// Shared types, widths and helpers for the damped double integrator.
// Used by ddi_mul and damped_double_integrator.
package ddi_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int VALUE_FRAC  = 16;
  localparam int COEF_WIDTH  = 32;
  localparam int COEF_FRAC   = 30;
  localparam int PROD_WIDTH  = VALUE_WIDTH + COEF_WIDTH;
  localparam int TERM_WIDTH  = PROD_WIDTH - COEF_FRAC;
  localparam int ACC_WIDTH   = TERM_WIDTH + 2;
  localparam int CFG_IDX_WIDTH = 2;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic signed [COEF_WIDTH-1:0]  coef_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [TERM_WIDTH-1:0]  term_t;
  typedef logic signed [ACC_WIDTH-1:0]   acc_t;
  typedef logic [1:0]                    req_t;
  typedef logic [CFG_IDX_WIDTH-1:0]      cfg_index_t;

  localparam req_t REQ_STEP   = 2'd0;
  localparam req_t REQ_BACKUP = 2'd1;
  localparam req_t REQ_REDO   = 2'd2;
  localparam req_t REQ_LOAD   = 2'd3;

  localparam cfg_index_t CFG_POLE  = 2'd0;
  localparam cfg_index_t CFG_INPUT = 2'd1;
  localparam cfg_index_t CFG_HALF  = 2'd2;

  localparam coef_t POLE_RESET  = coef_t'(1073741824);
  localparam coef_t INPUT_RESET = coef_t'(536871);
  localparam coef_t HALF_RESET  = coef_t'(536871);

  function automatic value_t sat_value(acc_t x);
    logic [ACC_WIDTH-VALUE_WIDTH:0] top;
    top = x[ACC_WIDTH-1:VALUE_WIDTH-1];
    if (&top || ~|top) begin
      return x[VALUE_WIDTH-1:0];
    end
    return x[ACC_WIDTH-1] ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                          : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  endfunction

endpackage

/* rtl/core/ddi_mul.sv */
// Shared signed coefficient-by-value multiplier with registered product.
// Rounds the product to the value's 16 fraction bits in a wider term. Depends on ddi_pkg.
module ddi_mul (
  input  logic           clk,
  input  ddi_pkg::coef_t  coef,
  input  ddi_pkg::value_t value,
  output ddi_pkg::term_t  term
);
  import ddi_pkg::*;

  prod_t prod;

  always_ff @(posedge clk) begin
    prod <= prod_t'(coef) * prod_t'(value);
  end

  assign term = term_t'(prod[PROD_WIDTH-1:COEF_FRAC]) +
                term_t'({1'b0, prod[COEF_FRAC-1]});

endmodule

/* rtl/core/damped_double_integrator.sv */
// Top level of the Tustin damped double integrator: sequencer, state,
// backups, coefficient registers and output register. Depends on ddi_pkg, ddi_mul.
//
//  channel | signals                                        | role
//  in      | in_valid in_ready req_type u_value y_init sy_init | one request item
//  out     | out_valid out_ready first_integral second_integral | one result item
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data          | coefficient writes
//
// A step item is accepted in the idle state; the sequencer then pushes five products
// one per cycle through the registered shared multiplier, the final state hands the
// result to the output register, and the idle state takes the next item.
// A load item sets the integrals and goes straight to the final state.
// Reset is synchronous; state, backups and coefficients take their reset values.
// A stalled output holds the sequencer in its final state until taken.
module damped_double_integrator (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ddi_pkg::req_t        req_type,
  input  ddi_pkg::value_t      u_value,
  input  ddi_pkg::value_t      y_init,
  input  ddi_pkg::value_t      sy_init,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ddi_pkg::value_t      first_integral,
  output ddi_pkg::value_t      second_integral,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  ddi_pkg::cfg_index_t  cfg_index,
  input  ddi_pkg::coef_t       cfg_data
);
  import ddi_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam logic [2:0] LAST_STEP = 3'd5;

  logic [1:0] state;
  logic [2:0] step;

  coef_t  pole_coef, input_coef, half_step;
  value_t first_acc, second_acc, prev_input;
  value_t first_backup, second_backup, input_backup;
  value_t w_sy, w_y, w_up, w_u;
  acc_t   acc;
  acc_t   acc_sum;

  coef_t  mul_coef;
  value_t mul_value;
  term_t  term;

  logic in_fire, out_free;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign acc_sum   = acc + acc_t'(term);

  always_comb begin
    case (step)
      3'd0: begin
        mul_coef  = pole_coef;
        mul_value = w_sy;
      end
      3'd1: begin
        mul_coef  = input_coef;
        mul_value = w_u;
      end
      3'd2: begin
        mul_coef  = input_coef;
        mul_value = w_up;
      end
      3'd3: begin
        mul_coef  = half_step;
        mul_value = w_sy;
      end
      3'd4: begin
        mul_coef  = half_step;
        mul_value = first_acc;
      end
      default: begin
        mul_coef  = pole_coef;
        mul_value = w_sy;
      end
    endcase
  end

  ddi_mul u_mul (
    .clk   (clk),
    .coef  (mul_coef),
    .value (mul_value),
    .term  (term)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pole_coef  <= POLE_RESET;
      input_coef <= INPUT_RESET;
      half_step  <= HALF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POLE:  pole_coef  <= cfg_data;
        CFG_INPUT: input_coef <= cfg_data;
        CFG_HALF:  half_step  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      step          <= '0;
      out_valid     <= 1'b0;
      first_acc     <= '0;
      second_acc    <= '0;
      prev_input    <= '0;
      first_backup  <= '0;
      second_backup <= '0;
      input_backup  <= '0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            step <= '0;
            w_u  <= u_value;
            if (req_type == REQ_REDO) begin
              w_sy <= first_backup;
              w_y  <= second_backup;
              w_up <= input_backup;
            end else begin
              w_sy <= first_acc;
              w_y  <= second_acc;
              w_up <= prev_input;
            end
            if (req_type == REQ_BACKUP) begin
              first_backup  <= first_acc;
              second_backup <= second_acc;
              input_backup  <= prev_input;
            end
            if (req_type == REQ_LOAD) begin
              first_acc  <= sy_init;
              second_acc <= y_init;
              prev_input <= u_value;
              state      <= S_DONE;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          step <= step + 3'd1;
          case (step)
            3'd1: acc <= acc_t'(term);
            3'd2: acc <= acc_sum;
            3'd3: begin
              first_acc <= sat_value(acc_sum);
              acc       <= acc_t'(w_y);
            end
            3'd4: acc <= acc_sum;
            3'd5: begin
              second_acc <= sat_value(acc_sum);
              prev_input <= w_u;
              state      <= S_DONE;
            end
            default: begin
            end
          endcase
        end
        S_DONE: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            first_integral  <= first_acc;
            second_integral <= second_acc;
            state           <= S_IDLE;
          end else begin
            out_valid       <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside the final state");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> step <= LAST_STEP)
    else $error("sequencer step out of range");

  a_load: assert property (@(posedge clk) disable iff (rst)
    in_fire && req_type == REQ_LOAD |=>
      first_acc == $past(sy_init) && second_acc == $past(y_init) && state == S_DONE)
    else $error("load did not set the integrals");

  a_backup_hold: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |=> $stable(first_backup) && $stable(second_backup)
      && $stable(input_backup))
    else $error("backup changed while busy");

endmodule
